// File: hw/rtl/trq_pkg.sv
// package for the timestamp release queue
// holds the queue entry type, result status codes, register indexes and fixed sizes
// no dependencies
package trq_pkg;

  localparam int unsigned WORDS = 4;
  localparam int unsigned MAX_MESSAGE_BYTES = 16;
  localparam logic [31:0] SEND_OVERHEAD_RST = 32'd100;

  typedef struct packed {
    logic [63:0]            tstamp;
    logic [4:0]             nbytes;
    logic [WORDS-1:0][31:0] words;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rel;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    STATUS_SENT     = 2'd0,
    STATUS_RELEASED = 2'd1,
    STATUS_OVERSIZE = 2'd2,
    STATUS_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_ENABLE         = 2'd0,
    CFG_TICK_WINDOW    = 2'd1,
    CFG_DEVICE_LATENCY = 2'd2,
    CFG_SEND_OVERHEAD  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FUNC_MESSAGE = 1'b0,
    FUNC_TICK    = 1'b1
  } func_e;

endpackage

// File: hw/rtl/trq_cell.sv
// one slot of the sorted release chain
// holds one queued message, shifts right on insert and left on release
// depends on trq_pkg
module trq_cell (
  input  logic               clk_i,
  input  trq_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  trq_pkg::entry_t    new_i,
  input  logic               left_take_i,
  input  trq_pkg::entry_t    left_i,
  input  trq_pkg::entry_t    right_i,
  output logic               take_o,
  output trq_pkg::entry_t    entry_o
);
  import trq_pkg::*;

  entry_t entry_q, entry_d;

  // new message lands here or before here (strict compare keeps ties in arrival order)
  assign take_o = !occ_i || (entry_q.tstamp > new_i.tstamp);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.rel) begin
      entry_d = right_i;
    end else if (ctl_i.ins && take_o) begin
      entry_d = left_take_i ? left_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hw/rtl/timestamp_release_queue.sv
// top level of the timestamp release queue
// config registers, pass/release decisions, result register and the chain of trq_cell slots
// depends on trq_pkg and trq_cell
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------------------------------------
//   in       | request   | in_valid_i / in_stall_o   | func, in_word0..3, in_bytes, due, now
//   out      | result    | out_valid_o / out_stall_i | status, out_word0..3, out_bytes, time
//   cfg      | write     | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// one request per cycle while the input is not stalled; a request that makes a result has it
// in the output register in the cycle after it is taken; every slot compares its timestamp
// with the incoming one together, so an insert or release is one chain update at any occupancy
// the input stalls only while a result waits in the output register and out is stalled
// reset empties the queue, restores the register defaults and clears the output valid flag
module timestamp_release_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] in_word0_i,
  input  logic [31:0] in_word1_i,
  input  logic [31:0] in_word2_i,
  input  logic [31:0] in_word3_i,
  input  logic [4:0]  in_bytes_i,
  input  logic [63:0] due_time_i,
  input  logic [63:0] now_time_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_word0_o,
  output logic [31:0] out_word1_o,
  output logic [31:0] out_word2_o,
  output logic [31:0] out_word3_o,
  output logic [4:0]  out_bytes_o,
  output logic [63:0] out_time_o
);
  import trq_pkg::*;

  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

  // config registers; the two sums are kept ready so each due check is one add and compare
  logic        enable_q, enable_d;
  logic [31:0] tick_window_q, tick_window_d;
  logic [31:0] dev_lat_q, dev_lat_d;
  logic [31:0] send_ovh_q, send_ovh_d;
  logic [32:0] pass_win_q, pass_win_d;  // tick_window + device_latency
  logic [32:0] rel_win_q, rel_win_d;    // device_latency + send_overhead

  always_comb begin
    enable_d      = enable_q;
    tick_window_d = tick_window_q;
    dev_lat_d     = dev_lat_q;
    send_ovh_d    = send_ovh_q;
    pass_win_d    = pass_win_q;
    rel_win_d     = rel_win_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE: begin
          enable_d = cfg_wdata_i[0];
        end
        CFG_TICK_WINDOW: begin
          tick_window_d = cfg_wdata_i;
          pass_win_d    = {1'b0, cfg_wdata_i} + {1'b0, dev_lat_q};
        end
        CFG_DEVICE_LATENCY: begin
          dev_lat_d  = cfg_wdata_i;
          pass_win_d = {1'b0, tick_window_q} + {1'b0, cfg_wdata_i};
          rel_win_d  = {1'b0, cfg_wdata_i} + {1'b0, send_ovh_q};
        end
        CFG_SEND_OVERHEAD: begin
          send_ovh_d = cfg_wdata_i;
          rel_win_d  = {1'b0, dev_lat_q} + {1'b0, cfg_wdata_i};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b1;
      tick_window_q <= '0;
      dev_lat_q     <= '0;
      send_ovh_q    <= SEND_OVERHEAD_RST;
      pass_win_q    <= '0;
      rel_win_q     <= {1'b0, SEND_OVERHEAD_RST};
    end else begin
      enable_q      <= enable_d;
      tick_window_q <= tick_window_d;
      dev_lat_q     <= dev_lat_d;
      send_ovh_q    <= send_ovh_d;
      pass_win_q    <= pass_win_d;
      rel_win_q     <= rel_win_d;
    end
  end

  // request decode
  logic       out_valid_q, out_valid_d;
  logic       in_acc, active, is_tick, oversize, pass_now, full, rel_ok;
  logic [OCC_W-1:0] occ_q, occ_d;
  entry_t     new_entry;
  entry_t     ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] take;
  cell_ctl_t  ctl;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign active     = in_acc & enable_q;
  assign is_tick    = (func_e'(func_i) == FUNC_TICK);
  assign oversize   = in_bytes_i > 5'(MAX_MESSAGE_BYTES);
  assign full       = (occ_q == OCC_W'(QUEUE_DEPTH));

  // saturating due minus windows compared against now, rewritten as now + window >= due
  assign pass_now = ({1'b0, now_time_i} + {32'b0, pass_win_q}) >= {1'b0, due_time_i};
  assign rel_ok   = (occ_q != '0) &&
                    (({1'b0, now_time_i} + {32'b0, rel_win_q}) >= {1'b0, ent[0].tstamp});

  assign new_entry.tstamp = due_time_i;
  assign new_entry.nbytes = in_bytes_i;
  assign new_entry.words  = {in_word3_i, in_word2_i, in_word1_i, in_word0_i};

  assign ctl.ins = active & ~is_tick & ~oversize & ~pass_now & ~full;
  assign ctl.rel = active & is_tick & rel_ok;

  always_comb begin
    occ_d = occ_q;
    if (ctl.ins) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (ctl.rel) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  // the chain: slot 0 is the head, slots shift right on insert and left on release
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_take;
    if (i == 0) begin : g_head
      assign left_ent  = new_entry;
      assign left_take = 1'b0;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign left_take = take[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    trq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ_q > OCC_W'(i)),
      .new_i       (new_entry),
      .left_take_i (left_take),
      .left_i      (left_ent),
      .right_i     (right_ent),
      .take_o      (take[i]),
      .entry_o     (ent[i])
    );
  end

  // result selection into the output register
  logic             emit;
  status_e          res_status_q, res_status_d;
  logic [3:0][31:0] res_words_q, res_words_d;
  logic [4:0]       res_bytes_q, res_bytes_d;
  logic [63:0]      res_time_q, res_time_d;

  always_comb begin
    emit         = 1'b0;
    res_status_d = STATUS_SENT;
    res_words_d  = '0;
    res_bytes_d  = '0;
    res_time_d   = due_time_i;
    if (active) begin
      if (is_tick) begin
        if (rel_ok) begin
          emit         = 1'b1;
          res_status_d = STATUS_RELEASED;
          res_words_d  = ent[0].words;
          res_bytes_d  = ent[0].nbytes;
          res_time_d   = ent[0].tstamp;
        end
      end else if (oversize) begin
        emit         = 1'b1;
        res_status_d = STATUS_OVERSIZE;
      end else if (pass_now) begin
        emit         = 1'b1;
        res_status_d = STATUS_SENT;
        res_words_d  = new_entry.words;
        res_bytes_d  = in_bytes_i;
      end else if (full) begin
        emit         = 1'b1;
        res_status_d = STATUS_FULL;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      occ_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      occ_q       <= occ_d;
    end
  end

  // payload only loads on a new result
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_status_q <= res_status_d;
      res_words_q  <= res_words_d;
      res_bytes_q  <= res_bytes_d;
      res_time_q   <= res_time_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_status_q;
  assign out_word0_o = res_words_q[0];
  assign out_word1_o = res_words_q[1];
  assign out_word2_o = res_words_q[2];
  assign out_word3_o = res_words_q[3];
  assign out_bytes_o = res_bytes_q;
  assign out_time_o  = res_time_q;

  // occupancy never runs past the chain length
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  // an insert grows the queue by exactly one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins |=> occ_q == $past(occ_q) + OCC_W'(1))
    else $error("insert did not grow the queue");

  // a release always shows up as a released result
  a_rel_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rel |=> out_valid_o && status_o == STATUS_RELEASED)
    else $error("release without released result");

  // head of the chain is never later than its neighbour
  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q >= OCC_W'(2) |-> ent[0].tstamp <= ent[1].tstamp)
    else $error("chain out of order at head");

endmodule

// File: bench/timestamp_release_queue_tb.sv
// testbench for timestamp_release_queue: directed and random requests against a predictor
// of the earliest-first queue, results checked field by field in arrival order
// depends on trq_pkg and the timestamp_release_queue rtl
module timestamp_release_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trq_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LIMIT_CYCLES  = 400000;

  // one request as the sender sees it
  typedef struct {
    func_e                  func;
    logic [WORDS-1:0][31:0] words;
    logic [4:0]             nbytes;
    logic [63:0]            due;
    logic [63:0]            now;
  } msg_req_t;

  // one result as the receiver sees it
  typedef struct {
    status_e                status;
    logic [WORDS-1:0][31:0] words;
    logic [4:0]             nbytes;
    logic [63:0]            stamp;
  } tx_result_t;

  // shapes of random request runs
  typedef enum int unsigned {
    SEQ_FILL,
    SEQ_DRAIN,
    SEQ_MIXED,
    SEQ_NOISE
  } seq_kind_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = CFG_ENABLE;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        func_i      = FUNC_MESSAGE;
  logic [31:0] in_word0_i  = '0;
  logic [31:0] in_word1_i  = '0;
  logic [31:0] in_word2_i  = '0;
  logic [31:0] in_word3_i  = '0;
  logic [4:0]  in_bytes_i  = '0;
  logic [63:0] due_time_i  = '0;
  logic [63:0] now_time_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] out_word0_o;
  logic [31:0] out_word1_o;
  logic [31:0] out_word2_o;
  logic [31:0] out_word3_o;
  logic [4:0]  out_bytes_o;
  logic [63:0] out_time_o;

  timestamp_release_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .in_word0_i  (in_word0_i),
    .in_word1_i  (in_word1_i),
    .in_word2_i  (in_word2_i),
    .in_word3_i  (in_word3_i),
    .in_bytes_i  (in_bytes_i),
    .due_time_i  (due_time_i),
    .now_time_i  (now_time_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .out_word0_o (out_word0_o),
    .out_word1_o (out_word1_o),
    .out_word2_o (out_word2_o),
    .out_word3_o (out_word3_o),
    .out_bytes_o (out_bytes_o),
    .out_time_o  (out_time_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers, reset values
  bit          en_q          = 1'b1;
  logic [31:0] tick_window_q = '0;
  logic [31:0] dev_latency_q = '0;
  logic [31:0] send_ovh_q    = SEND_OVERHEAD_RST;

  // held messages, earliest due first, and results still to arrive
  entry_t      held_q[$];
  tx_result_t  expected_q[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  logic [63:0] cur_now     = '0;
  logic [63:0] last_due    = '0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] sat_minus(input logic [63:0] a, input logic [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  // earliest tick time at which a held message may leave
  function automatic logic [63:0] release_point(input logic [63:0] stamp);
    return sat_minus(sat_minus(stamp, 64'(dev_latency_q)), 64'(send_ovh_q));
  endfunction

  // works out what one accepted request causes and updates the held queue
  function automatic void predict_result(input msg_req_t r);
    entry_t     e;
    tx_result_t res;
    int         pos;
    if (!en_q) return;
    if (r.func == FUNC_TICK) begin
      // only ticks release, and only the head once its time has come
      if (held_q.size() == 0) return;
      if (r.now < release_point(held_q[0].tstamp)) return;
      e = held_q.pop_front();
      res = '{STATUS_RELEASED, e.words, e.nbytes, e.tstamp};
      expected_q.push_back(res);
      return;
    end
    if (r.nbytes > MAX_MESSAGE_BYTES) begin
      res = '{STATUS_OVERSIZE, '0, 5'd0, r.due};
      expected_q.push_back(res);
    end else if (r.now >= sat_minus(sat_minus(r.due, 64'(tick_window_q)),
                                    64'(dev_latency_q))) begin
      res = '{STATUS_SENT, r.words, r.nbytes, r.due};
      expected_q.push_back(res);
    end else if (held_q.size() >= DEPTH) begin
      res = '{STATUS_FULL, '0, 5'd0, r.due};
      expected_q.push_back(res);
    end else begin
      // stable insert: equal due times keep arrival order
      e.tstamp = r.due;
      e.nbytes = r.nbytes;
      e.words  = r.words;
      pos = held_q.size();
      while (pos > 0 && held_q[pos-1].tstamp > r.due) pos--;
      held_q.insert(pos, e);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  function automatic msg_req_t build_req(input func_e f, input logic [4:0] nb,
                                         input logic [63:0] due, input logic [63:0] now,
                                         input logic [31:0] w);
    msg_req_t r;
    r.func   = f;
    r.words  = {4{w}};
    r.nbytes = nb;
    r.due    = due;
    r.now    = now;
    return r;
  endfunction

  // random request of the given run shape; moves the running time forward
  function automatic msg_req_t make_request(input seq_kind_e seq);
    msg_req_t    r;
    logic [63:0] span, step, lead;
    bit          is_tick;
    span = 64'(tick_window_q) + 64'(dev_latency_q) + 64'(send_ovh_q);
    step = span / 16 + 64'd30;
    lead = 64'(tick_window_q) + 64'(dev_latency_q);
    r.words  = {$urandom, $urandom, $urandom, $urandom};
    r.nbytes = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
    case (seq)
      SEQ_FILL:  is_tick = ($urandom_range(0, 7) == 0);
      SEQ_DRAIN: is_tick = ($urandom_range(0, 5) != 0);
      default:   is_tick = 1'($urandom_range(0, 1));
    endcase
    if (is_tick) begin
      r.func = FUNC_TICK;
      r.due  = rand64();
      cur_now += rand64() % step;
      r.now = cur_now;
      // aim at the head's release edge now and then
      if (held_q.size() != 0 && $urandom_range(0, 3) == 0)
        r.now = release_point(held_q[0].tstamp) + 64'($urandom_range(0, 2)) - 64'd1;
    end else begin
      r.func = FUNC_MESSAGE;
      cur_now += rand64() % (step / 4 + 64'd1);
      r.now = cur_now;
      if (seq == SEQ_FILL) begin
        // mostly beyond the early window so it gets held, now and then the last due time again
        if ($urandom_range(0, 5) == 0)
          r.due = last_due;
        else
          r.due = cur_now + lead + 64'd1 + rand64() % (64'(send_ovh_q) + 64'd400);
      end else begin
        case ($urandom_range(0, 3))
          0:       r.due = cur_now + 64'($urandom_range(0, 300));
          1:       r.due = cur_now + lead + 64'($urandom_range(0, 4)) - 64'd2;
          2:       r.due = cur_now + rand64() % (span + 64'd500);
          default: r.due = last_due;
        endcase
      end
      last_due = r.due;
    end
    if (seq == SEQ_NOISE) begin
      r.nbytes = 5'($urandom_range(0, 31));
      r.now    = $urandom_range(0, 1) ? rand64() : cur_now - 64'($urandom_range(0, 500));
      if (!is_tick) r.due = rand64();
    end
    return r;
  endfunction

  // sender drops valid and idles; a zero count leaves valid as it is
  task automatic idle_sender(input int unsigned n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // one request: bursts with random gaps between them, held until taken
  task automatic send_request(input msg_req_t r);
    bit taken;
    if (burst_left == 0) begin
      idle_sender($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    func_i     <= r.func;
    in_word0_i <= r.words[0];
    in_word1_i <= r.words[1];
    in_word2_i <= r.words[2];
    in_word3_i <= r.words[3];
    in_bytes_i <= r.nbytes;
    due_time_i <= r.due;
    now_time_i <= r.now;
    taken = 1'b0;
    // stall is settled by the falling edge, acceptance happens on the next rising one
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    predict_result(r);
  endtask

  // sender holds off until every expected result is in, then lets the block settle
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLE:         en_q          = val[0];
      CFG_TICK_WINDOW:    tick_window_q = val;
      CFG_DEVICE_LATENCY: dev_latency_q = val;
      default:            send_ovh_q    = val;
    endcase
  endtask

  task automatic write_delays(input logic [31:0] tw, input logic [31:0] dl,
                              input logic [31:0] so);
    write_reg(CFG_TICK_WINDOW, tw);
    write_reg(CFG_DEVICE_LATENCY, dl);
    write_reg(CFG_SEND_OVERHEAD, so);
  endtask

  // ticks at the latest possible time empty the queue one entry each
  task automatic flush_queue();
    while (held_q.size() != 0)
      send_request(build_req(FUNC_TICK, 5'($urandom_range(0, 31)), rand64(), '1, $urandom));
    wait_results_done();
  endtask

  task automatic run_traffic(input int unsigned n_items, input logic [63:0] base);
    int unsigned done_items, len, pick;
    seq_kind_e   seq;
    cur_now    = base;
    last_due   = base;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 3)      seq = SEQ_FILL;
      else if (pick < 6) seq = SEQ_DRAIN;
      else if (pick < 9) seq = SEQ_MIXED;
      else               seq = SEQ_NOISE;
      len = $urandom_range(3, 20);
      repeat (len) begin
        send_request(make_request(seq));
        done_items++;
      end
      // occasional full hold-off so the output side drains completely
      if ($urandom_range(0, 11) == 0) wait_results_done();
    end
    wait_results_done();
  endtask

  // reset registers: every path but a full queue, saturation at both ends, ordering of equal due times
  task automatic test_directed_paths();
    send_request(build_req(FUNC_MESSAGE, 5'd0,  64'd0,    64'd0,   32'h0));     // due zero
    send_request(build_req(FUNC_MESSAGE, 5'd16, '1,       '1,      '1));        // all ones
    send_request(build_req(FUNC_MESSAGE, 5'd17, 64'd1000, 64'd0,   $urandom));  // oversize, held path
    send_request(build_req(FUNC_MESSAGE, 5'd31, 64'd5,    64'd10,  '1));        // oversize, pass path
    send_request(build_req(FUNC_TICK,    5'd0,  64'd0,    '1,      $urandom));  // empty queue
    send_request(build_req(FUNC_MESSAGE, 5'd4,  64'd500,  64'd100, $urandom));
    send_request(build_req(FUNC_MESSAGE, 5'd8,  64'd300,  64'd100, $urandom));  // goes ahead
    send_request(build_req(FUNC_MESSAGE, 5'd12, 64'd500,  64'd100, $urandom));  // equal due
    send_request(build_req(FUNC_TICK,    5'd0,  64'd0,    64'd199, $urandom));  // one short
    send_request(build_req(FUNC_MESSAGE, 5'd1,  64'd150,  64'd250, $urandom));  // no release
    send_request(build_req(FUNC_TICK,    5'd0,  64'd0,    64'd200, $urandom));
    send_request(build_req(FUNC_TICK,    5'd0,  64'd0,    64'd399, $urandom));
    send_request(build_req(FUNC_TICK,    5'd0,  64'd0,    64'd400, $urandom));
    send_request(build_req(FUNC_TICK,    5'd0,  64'd0,    64'd400, $urandom));
    send_request(build_req(FUNC_MESSAGE, 5'd2,  64'd50,   64'd0,   $urandom));  // release saturates
    send_request(build_req(FUNC_TICK,    5'd0,  64'd0,    64'd0,   $urandom));
    send_request(build_req(FUNC_MESSAGE, 5'd16, '1,       64'd0,   32'h0));     // latest due
    send_request(build_req(FUNC_TICK,    5'd0,  64'd0,    64'hFFFF_FFFF_FFFF_FF9A, $urandom));
    send_request(build_req(FUNC_TICK,    5'd0,  64'd0,    64'hFFFF_FFFF_FFFF_FF9B, $urandom));
    wait_results_done();
  endtask

  // reset registers, times close to zero
  task automatic test_default_registers();
    run_traffic(300, 64'($urandom_range(0, 2000)));
    flush_queue();
  endtask

  task automatic test_window_and_latency();
    write_delays(32'd60, 32'd15, 32'd40);
    run_traffic(300, rand64() >> 1);
    flush_queue();
  endtask

  // widest registers with times near the top of the range
  task automatic test_extreme_registers();
    write_delays('1, '1, '1);
    run_traffic(250, 64'hFFFF_FF00_0000_0000 + 64'($urandom));
    flush_queue();
  endtask

  // entries are left held on purpose for the disabled test
  task automatic test_zero_delays();
    write_delays('0, '0, '0);
    run_traffic(250, rand64() >> 4);
  endtask

  // nothing comes out and the held entries survive until re-enabled
  task automatic test_disabled_input();
    write_reg(CFG_ENABLE, 32'h0);
    repeat (40) begin
      if ($urandom_range(0, 1))
        send_request(build_req(FUNC_TICK, 5'($urandom_range(0, 31)), rand64(), '1, $urandom));
      else
        send_request(make_request(SEQ_NOISE));
    end
    wait_results_done();
    write_reg(CFG_ENABLE, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_registers();
    repeat (3) begin
      write_delays($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 600)),
                   $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 600)),
                   $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 600)));
      run_traffic(120, rand64() >> 2);
      flush_queue();
    end
  endtask

  // receiver stall pattern: no stall, light, heavy or periodic, switching at random
  int unsigned rx_mode  = 0;
  int unsigned rx_left  = 0;
  int unsigned rx_phase = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(40, 300);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 4) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((rx_phase % 10) < 6);
    endcase
  end

  // a result valid and unstalled at the falling edge is taken at the next rising edge
  always @(negedge clk_i) begin : result_check
    tx_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        $error("result with none expected: status %0d, time %0h", status_o, out_time_o);
      end else begin
        want = expected_q.pop_front();
        check_field("status",    64'(want.status),   64'(status_o));
        check_field("out_word0", 64'(want.words[0]), 64'(out_word0_o));
        check_field("out_word1", 64'(want.words[1]), 64'(out_word1_o));
        check_field("out_word2", 64'(want.words[2]), 64'(out_word2_o));
        check_field("out_word3", 64'(want.words[3]), 64'(out_word3_o));
        check_field("out_bytes", 64'(want.nbytes),   64'(out_bytes_o));
        check_field("out_time",  want.stamp,         out_time_o);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timestamp_release_queue verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_paths();
    test_default_registers();
    test_window_and_latency();
    test_extreme_registers();
    test_zero_delays();
    test_disabled_input();
    test_random_registers();
    wait_results_done();
    if (fail_count == 0)
      $display("timestamp_release_queue verification clean");
    else
      $display("timestamp_release_queue verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/trq_pkg.sv
hw/rtl/trq_cell.sv
hw/rtl/timestamp_release_queue.sv
bench/timestamp_release_queue_tb.sv
